/* rtl/core/wet_pkg.sv */
// ----------------------------------------------------------------------------
// wet_pkg
// Shared types and constants for the windowed extremum tracker.
// ----------------------------------------------------------------------------
package wet_pkg;

   localparam int WIN_WIDTH       = 32;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [WIN_WIDTH-1:0] WINDOW_RESET = 32'd1024;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_WINDOW_LENGTH = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TRACK_MAX     = 1'd1;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture the accepted sample
      logic eval;     // restart or partial replacement
      logic shift;    // shift out one expired leading candidate
      logic refresh;  // sub-window refresh
      logic publish;  // load the result register
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic restart;  // all candidates restart to the sample
      logic expired;  // candidate 0 lies outside the window
      logic out_free; // result register can take a new value
   } dp_status_type;

endpackage

/* rtl/core/windowed_extremum_tracker_unit.sv */
// ----------------------------------------------------------------------------
// windowed_extremum_tracker_unit
// Running minimum or maximum over a sliding time window.
// ----------------------------------------------------------------------------
// Each sample transfer yields one result: the best value seen inside the
// last window_length time units (minimum, or maximum when track_max is set).
// Samples are processed one at a time by a small sequencer. After evaluation
// a sample goes straight to publish when all candidates restart, through a
// refresh step when no candidate expires, or through expiry shifts, one per
// cycle, when leading candidates leave the window. The result sits in an
// output register, so the next sample is taken while a result still waits; a
// result held back longer than the next sample's processing delays that
// sample's completion. Timestamps wrap. The user must write configuration
// while no sample is in flight; the block itself does not enforce this.
module windowed_extremum_tracker_unit import wet_pkg::*; #(
   parameter int NUM_CANDIDATES = 3,
   parameter int TIME_WIDTH     = 32,
   parameter int VALUE_WIDTH    = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic [TIME_WIDTH-1:0]         req_sample_time,
   input  logic signed [VALUE_WIDTH-1:0] req_sample_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [VALUE_WIDTH-1:0] rsp_extremum_value
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   wet_ctrl #(
      .NUM_CANDIDATES (NUM_CANDIDATES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   wet_datapath #(
      .NUM_CANDIDATES (NUM_CANDIDATES),
      .TIME_WIDTH     (TIME_WIDTH),
      .VALUE_WIDTH    (VALUE_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_kind           (req_kind),
      .req_sample_time    (req_sample_time),
      .req_sample_value   (req_sample_value),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_extremum_value (rsp_extremum_value),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

/* rtl/core/wet_ctrl.sv */
// ----------------------------------------------------------------------------
// wet_ctrl
// Sequencer for one sample: evaluate, expiry shifts or refresh, publish.
// ----------------------------------------------------------------------------
module wet_ctrl import wet_pkg::*; #(
   parameter int NUM_CANDIDATES = 3
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam int CNT_W = $clog2(NUM_CANDIDATES + 1);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_EVAL    = 5'b00010,
      ST_SHIFT   = 5'b00100,
      ST_REFRESH = 5'b01000,
      ST_DONE    = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] shift_cnt_ff, shift_cnt_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      shift_cnt_in = shift_cnt_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval     = 1'b1;
            shift_cnt_in = '0;
            if (status.restart) begin
               state_in = ST_DONE;
            end else if (status.expired) begin
               state_in = ST_SHIFT;
            end else begin
               state_in = ST_REFRESH;
            end
         end
         ST_SHIFT: begin
            // at most one shift per candidate
            if (status.expired && (shift_cnt_ff < CNT_W'(NUM_CANDIDATES))) begin
               cmd.shift    = 1'b1;
               shift_cnt_in = shift_cnt_ff + 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_REFRESH: begin
            cmd.refresh = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         shift_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         shift_cnt_ff <= shift_cnt_in;
      end
   end

endmodule

/* rtl/core/wet_datapath.sv */
// ----------------------------------------------------------------------------
// wet_datapath
// Candidate list, configuration registers, comparators and result register.
// ----------------------------------------------------------------------------
module wet_datapath import wet_pkg::*; #(
   parameter int NUM_CANDIDATES = 3,
   parameter int TIME_WIDTH     = 32,
   parameter int VALUE_WIDTH    = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_data,
   input  logic                          req_kind,
   input  logic [TIME_WIDTH-1:0]         req_sample_time,
   input  logic signed [VALUE_WIDTH-1:0] req_sample_value,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic signed [VALUE_WIDTH-1:0] rsp_extremum_value,
   input  ctrl_cmd_type                  cmd,
   output dp_status_type                 status
);

   localparam int CMP_W = (TIME_WIDTH > WIN_WIDTH) ? TIME_WIDTH : WIN_WIDTH;
   localparam int LAST  = NUM_CANDIDATES - 1;

   logic [WIN_WIDTH-1:0]         window_ff;
   logic                         track_max_ff;
   logic                         kind_ff;
   logic [TIME_WIDTH-1:0]        time_ff;
   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic [TIME_WIDTH-1:0]        cand_time_ff [NUM_CANDIDATES];
   logic signed [VALUE_WIDTH-1:0] cand_value_ff [NUM_CANDIDATES];
   logic [TIME_WIDTH-1:0]        cand_time_in [NUM_CANDIDATES];
   logic signed [VALUE_WIDTH-1:0] cand_value_in [NUM_CANDIDATES];
   logic                         rsp_valid_ff;
   logic signed [VALUE_WIDTH-1:0] rsp_value_ff;

   logic [NUM_CANDIDATES-1:0] good;
   logic [NUM_CANDIDATES-1:0] part_mask;
   logic [NUM_CANDIDATES-1:0] refr_mask;
   logic [NUM_CANDIDATES-1:0] fill_mask;
   logic [LAST-1:0]           refr_hit;
   logic [TIME_WIDTH-1:0]     age_first;
   logic [TIME_WIDTH-1:0]     age_last;
   logic [CMP_W-1:0]          age_first_x;
   logic [CMP_W-1:0]          age_last_x;
   logic [CMP_W-1:0]          win_x;
   logic                      run_part;
   logic                      run_refr;

   // wrapping ages against the oldest and newest candidates
   assign age_first   = time_ff - cand_time_ff[0];
   assign age_last    = time_ff - cand_time_ff[LAST];
   assign age_first_x = CMP_W'(age_first);
   assign age_last_x  = CMP_W'(age_last);
   assign win_x       = CMP_W'(window_ff);

   always_comb begin
      for (int k = 0; k < NUM_CANDIDATES; k++) begin
         // ties count as beating the candidate
         good[k] = track_max_ff ? (value_ff >= cand_value_ff[k])
                                : (value_ff <= cand_value_ff[k]);
      end
      for (int k = 0; k < LAST; k++) begin
         refr_hit[k] = (cand_time_ff[k] == cand_time_ff[k+1]) &&
                       ((win_x >> (LAST - k)) < age_first_x);
      end
      part_mask    = '0;
      refr_mask    = '0;
      run_part     = 1'b0;
      run_refr     = 1'b0;
      for (int k = 1; k < NUM_CANDIDATES; k++) begin
         run_part     = run_part | good[k];
         run_refr     = run_refr | refr_hit[k-1];
         part_mask[k] = run_part;
         refr_mask[k] = run_refr;
      end
   end

   assign status.restart  = kind_ff | good[0] | (age_last_x > win_x);
   assign status.expired  = (age_first_x > win_x);
   assign status.out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      fill_mask = '0;
      if (cmd.eval) begin
         fill_mask = status.restart ? '1 : part_mask;
      end else if (cmd.refresh) begin
         fill_mask = refr_mask;
      end
      for (int k = 0; k < NUM_CANDIDATES; k++) begin
         cand_time_in[k]  = cand_time_ff[k];
         cand_value_in[k] = cand_value_ff[k];
         if (cmd.shift) begin
            if (k == LAST) begin
               cand_time_in[k]  = time_ff;
               cand_value_in[k] = value_ff;
            end else begin
               cand_time_in[k]  = cand_time_ff[k+1];
               cand_value_in[k] = cand_value_ff[k+1];
            end
         end else if (fill_mask[k]) begin
            cand_time_in[k]  = time_ff;
            cand_value_in[k] = value_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_RESET;
         track_max_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_CANDIDATES; k++) begin
            cand_time_ff[k]  <= '0;
            cand_value_ff[k] <= '0;
         end
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_WINDOW_LENGTH: window_ff    <= csr_data[WIN_WIDTH-1:0];
               REG_TRACK_MAX:     track_max_ff <= csr_data[0];
               default:           ;
            endcase
         end
         for (int k = 0; k < NUM_CANDIDATES; k++) begin
            cand_time_ff[k]  <= cand_time_in[k];
            cand_value_ff[k] <= cand_value_in[k];
         end
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         time_ff  <= req_sample_time;
         value_ff <= req_sample_value;
      end
      if (cmd.publish) begin
         rsp_value_ff <= cand_value_ff[0];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_extremum_value = rsp_value_ff;

endmodule
